FILE: sv/websocket_frame_deframer_top_defines.svh
// Assertion macros used by the checker of the deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Check a property outside reset.
`define WSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define WSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/wsd_pkg.sv
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_REJECT  = 3'd2,
        PH_EXTLEN  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } wsd_phase_t;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_CNT  = 4'd2;
    localparam logic [3:0] EXT64_CNT  = 4'd8;
    localparam logic [2:0] KEY_BYTES  = 3'd4;

    typedef struct packed {
        logic       fin;
        logic       last;
        logic [7:0] data;
        logic [1:0] kind;
    } wsd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wsd_qstat_t;

endpackage

FILE: sv/wsd_front.sv
module wsd_front
    import wsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  wsd_qstat_t q_stat,
    output logic       push,
    output wsd_item_t  push_item
);

    wsd_phase_t  phase_reg, phase_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] pl_left_reg, pl_left_next;
    logic        masked_reg, masked_next;
    logic        fin_reg, fin_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  key_got_reg, key_got_next;
    logic [1:0]  key_pos_reg, key_pos_next;

    logic        in_fire;
    logic [6:0]  len7;
    logic        len_ext;
    logic [63:0] pl_dec;
    logic [63:0] ext_shift;
    logic [3:0]  ext_cnt_dec;
    logic [2:0]  key_got_inc;
    logic        key_done;
    logic [7:0]  key_byte;

    assign in_ready    = !q_stat.full;
    assign in_fire     = in_valid && in_ready;
    assign len7        = in_byte[6:0];
    assign len_ext     = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    assign pl_dec      = pl_left_reg - 64'd1;
    assign ext_shift   = {pl_left_reg[55:0], in_byte};
    assign ext_cnt_dec = (ext_left_reg != 4'd0) ? ext_left_reg - 4'd1 : 4'd0;
    assign key_got_inc = (key_got_reg < KEY_BYTES) ? key_got_reg + 3'd1 : key_got_reg;
    assign key_done    = !(key_got_inc < KEY_BYTES);

    always_comb begin
        case (key_pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            case (phase_reg)
                PH_HDR1: begin
                    if (len_ext) phase_next = PH_EXTLEN;
                    else if (in_byte[7]) phase_next = PH_KEY;
                    else if (len7 == 7'd0) phase_next = PH_HDR0;
                    else phase_next = PH_PAYLOAD;
                end
                PH_REJECT: phase_next = PH_HDR0;
                PH_EXTLEN: begin
                    if (ext_cnt_dec != 4'd0) phase_next = PH_EXTLEN;
                    else if (masked_reg) phase_next = PH_KEY;
                    else if (ext_shift == 64'd0) phase_next = PH_HDR0;
                    else phase_next = PH_PAYLOAD;
                end
                PH_KEY: begin
                    if (!key_done) phase_next = PH_KEY;
                    else if (pl_left_reg == 64'd0) phase_next = PH_HDR0;
                    else phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD: phase_next = (pl_dec == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                default: phase_next = (in_byte[3:0] == OPC_TEXT) ? PH_HDR1 : PH_REJECT;
            endcase
        end
    end

    always_comb begin
        ext_left_next  = ext_left_reg;
        pl_left_next   = pl_left_reg;
        masked_next    = masked_reg;
        fin_next       = fin_reg;
        key_next       = key_reg;
        key_got_next   = key_got_reg;
        key_pos_next   = key_pos_reg;
        push           = 1'b0;
        push_item.fin  = fin_reg;
        push_item.last = 1'b1;
        push_item.data = 8'd0;
        push_item.kind = KIND_EMPTY;
        if (in_fire) begin
            case (phase_reg)
                PH_HDR1: begin
                    masked_next = in_byte[7];
                    if (len7 == LEN_EXT16) begin
                        pl_left_next  = 64'd0;
                        ext_left_next = EXT16_CNT;
                    end else if (len7 == LEN_EXT64) begin
                        pl_left_next  = 64'd0;
                        ext_left_next = EXT64_CNT;
                    end else begin
                        pl_left_next = {57'd0, len7};
                        if (in_byte[7]) begin
                            key_got_next = 3'd0;
                            key_next     = 32'd0;
                        end else if (len7 == 7'd0) begin
                            push = 1'b1;
                        end else begin
                            key_pos_next = 2'd0;
                        end
                    end
                end
                PH_REJECT: begin
                    push           = 1'b1;
                    push_item.kind = KIND_REJECT;
                end
                PH_EXTLEN: begin
                    pl_left_next  = ext_shift;
                    ext_left_next = ext_cnt_dec;
                    if (ext_cnt_dec == 4'd0) begin
                        if (masked_reg) begin
                            key_got_next = 3'd0;
                            key_next     = 32'd0;
                        end else if (ext_shift == 64'd0) begin
                            push = 1'b1;
                        end else begin
                            key_pos_next = 2'd0;
                        end
                    end
                end
                PH_KEY: begin
                    key_next     = {key_reg[23:0], in_byte};
                    key_got_next = key_got_inc;
                    if (key_done) begin
                        if (pl_left_reg == 64'd0) push = 1'b1;
                        else key_pos_next = 2'd0;
                    end
                end
                PH_PAYLOAD: begin
                    pl_left_next   = pl_dec;
                    key_pos_next   = key_pos_reg + 2'd1;
                    push           = 1'b1;
                    push_item.kind = KIND_DATA;
                    push_item.data = masked_reg ? (in_byte ^ key_byte) : in_byte;
                    push_item.last = (pl_dec == 64'd0);
                end
                default: fin_next = in_byte[7];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            ext_left_reg <= 4'd0;
            pl_left_reg  <= 64'd0;
            masked_reg   <= 1'b0;
            fin_reg      <= 1'b0;
            key_reg      <= 32'd0;
            key_got_reg  <= 3'd0;
            key_pos_reg  <= 2'd0;
        end else begin
            phase_reg    <= phase_next;
            ext_left_reg <= ext_left_next;
            pl_left_reg  <= pl_left_next;
            masked_reg   <= masked_next;
            fin_reg      <= fin_next;
            key_reg      <= key_next;
            key_got_reg  <= key_got_next;
            key_pos_reg  <= key_pos_next;
        end
    end

endmodule

FILE: sv/wsd_queue.sv
module wsd_queue
    import wsd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  wsd_item_t  push_item,
    input  logic       pop,
    output wsd_item_t  pop_item,
    output wsd_qstat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsd_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_item     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop) rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop) count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/wsd_back.sv
module wsd_back
    import wsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  wsd_qstat_t q_stat,
    input  wsd_item_t  q_item,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [2:0] m_tuser,
    output logic       m_tlast
);

    logic      valid_reg, valid_next;
    wsd_item_t item_reg;

    assign pop = !q_stat.empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pop) item_reg <= q_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.data;
    assign m_tuser  = {item_reg.fin, item_reg.kind};
    assign m_tlast  = item_reg.last;

endmodule

FILE: sv/websocket_frame_deframer_top.sv
// Channel   | Dir | tdata          | tuser                          | tlast
// ----------+-----+----------------+--------------------------------+----------
// s_ (rx)   | in  | [7:0] rx_byte  | -                              | -
// m_ (out)  | out | [7:0] out_byte | [1:0] out_kind, [2] frame_fin  | out_last
//
// One received byte per cycle while s_tready is high; the parser updates its phase on each accepted byte.
// A result is registered in a queue slot, then in the output register, before it leaves.
// Synchronous active-low reset returns the parser to the first header byte.
// A stalled m_ side fills the queue; s_tready drops only when the queue is full.
module websocket_frame_deframer_top
    import wsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] out_kind, [2] frame_fin
    output logic       m_tlast
);

    wsd_qstat_t q_stat;
    wsd_item_t  push_item, pop_item;
    logic       push, pop;

    wsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    wsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_item   (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sv/wsd_checker.sv
`include "websocket_frame_deframer_top_defines.svh"

module wsd_checker
    import wsd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    logic        status_out;
    logic        in_idle;
    logic        out_stall;
    logic        kind_ok;
    logic [11:0] out_bus;

    assign status_out = m_tvalid && (m_tuser[1:0] != KIND_DATA);
    assign in_idle    = !s_tvalid;
    assign out_stall  = m_tvalid && !m_tready;
    assign out_bus    = {m_tlast, m_tuser, m_tdata};
    assign kind_ok    = (m_tuser[1:0] == KIND_DATA) || (m_tuser[1:0] == KIND_REJECT) ||
                        (m_tuser[1:0] == KIND_EMPTY);

    `WSD_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(out_bus), "output changed in stall")
    `WSD_ASSERT(a_status_form, status_out |-> (m_tdata == 8'd0) && m_tlast, "bad status result")
    `WSD_ASSERT(a_kind_legal, m_tvalid |-> kind_ok, "undefined result kind")
    `WSD_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "output valid right after reset")
    `WSD_ASSERT(a_no_spurious, in_idle [*4] |-> !m_tvalid || !$past(m_tready) || $past(m_tvalid), "result without input")

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (.*);
